### rtl/aopt_pkg.sv
// Shared types, constants and micro-operation codes of the arc odometry pose tracker.
`default_nettype none
package aopt_pkg;

  // Datapath widths.
  localparam int MW  = 40;  // multiplier operand width (signed)
  localparam int PW  = 80;  // multiplier product width (signed)
  localparam int CW  = 36;  // rotator x/y width
  localparam int ZW  = 33;  // rotator angle accumulator width
  localparam int SW  = 36;  // sine term width
  localparam int NW  = 65;  // dividend width (signed)
  localparam int DW  = 34;  // divisor width (signed)
  localparam int QW  = 66;  // quotient width (signed)
  localparam int LW  = 67;  // unclipped local move width
  localparam int LXW = 34;  // clipped local move width

  // Fixed-point constants.
  localparam logic [16:0] DIST_K           = 17'd93702;      // pi/2250 in Q26
  localparam logic [17:0] RAD_Q30_PER_UNIT = 18'd102944;     // 2*pi in Q14
  localparam logic [29:0] CORDIC_GAIN      = 30'd652032874;  // 1/K in Q30

  // Micro-operation codes; the program counter of the controller walks them.
  typedef logic [4:0] uop_t;
  localparam uop_t U_KDV      = 5'd0;
  localparam uop_t U_DV       = 5'd1;
  localparam uop_t U_KDH      = 5'd2;
  localparam uop_t U_DH       = 5'd3;
  localparam uop_t U_DIFF     = 5'd4;
  localparam uop_t U_DEN      = 5'd5;
  localparam uop_t U_SIN      = 5'd6;
  localparam uop_t U_SGAIN    = 5'd7;
  localparam uop_t U_PX       = 5'd8;
  localparam uop_t U_QX       = 5'd9;
  localparam uop_t U_OX       = 5'd10;
  localparam uop_t U_PY       = 5'd11;
  localparam uop_t U_QY       = 5'd12;
  localparam uop_t U_OY       = 5'd13;
  localparam uop_t U_STRAIGHT = 5'd14;
  localparam uop_t U_CLIP     = 5'd15;
  localparam uop_t U_ROT      = 5'd16;
  localparam uop_t U_GX       = 5'd17;
  localparam uop_t U_GY       = 5'd18;
  localparam uop_t U_ACC      = 5'd19;
  localparam uop_t U_SET      = 5'd20;

  // Unit that carries out a micro-operation.
  typedef logic [1:0] kind_t;
  localparam kind_t K_ALU = 2'd0;
  localparam kind_t K_MUL = 2'd1;
  localparam kind_t K_DIV = 2'd2;
  localparam kind_t K_COR = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    uop_t uop;
    logic load;
    logic issue;
    logic capture;
  } aopt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic is_set;
    logic dhead_zero;
    logic out_free;
  } aopt_stat_t;

  function automatic kind_t uop_kind(input uop_t u);
    kind_t k;
    case (u)
      U_KDV, U_DV, U_KDH, U_DH, U_DEN, U_SGAIN, U_PX, U_OX, U_PY, U_OY,
      U_GX, U_GY:    k = K_MUL;
      U_QX, U_QY:    k = K_DIV;
      U_SIN, U_ROT:  k = K_COR;
      default:       k = K_ALU;
    endcase
    return k;
  endfunction

  // Arctangent of 2^-i in units of 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/aopt_tick_if.sv
// Input channel carrying one sensor tick or set-pose item.
`default_nettype none
interface aopt_tick_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] vertical_angle;
  logic signed [31:0] horizontal_angle;
  logic        [15:0] heading_angle;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;

  modport source (output valid, op, vertical_angle, horizontal_angle, heading_angle,
                  start_x, start_y, input ready);
  modport sink (input valid, op, vertical_angle, horizontal_angle, heading_angle,
                start_x, start_y, output ready);
endinterface
`default_nettype wire

### rtl/aopt_pose_if.sv
// Output channel carrying one pose result.
`default_nettype none
interface aopt_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic               saturated;

  modport source (output valid, pos_x, pos_y, saturated, input ready);
  modport sink (input valid, pos_x, pos_y, saturated, output ready);
endinterface
`default_nettype wire

### rtl/aopt_mul.sv
// Shared signed multiplier that takes one byte of the second operand per cycle.
`default_nettype none
module aopt_mul
  import aopt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic signed [PW-1:0]      p,
  output logic                      done
);

  localparam int NB = MW / 8;
  localparam int CNTW = $clog2(NB);

  logic signed [MW-1:0]   a_r;
  logic        [MW-1:0]   b_r;
  logic        [CNTW-1:0] cnt;
  logic                   busy;
  logic        [7:0]      top_byte;
  logic signed [8:0]      byte_s;
  logic signed [MW+8:0]   partial;

  // The top byte is signed, all lower bytes are unsigned.
  always_comb begin
    top_byte = b_r[MW-1 -: 8];
    byte_s   = $signed({(cnt == '0) & top_byte[7], top_byte});
    partial  = a_r * byte_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        p    <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        p   <= (p <<< 8) + PW'(partial);
        b_r <= b_r << 8;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/aopt_div.sv
// Signed divider truncating toward zero, two quotient bits per cycle.
`default_nettype none
module aopt_div
  import aopt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] num,
  input  wire logic signed [DW-1:0] den,
  output logic signed [QW-1:0]      q,
  output logic                      done
);

  localparam int MAGW  = NW - 1;
  localparam int STEP  = 2;
  localparam int ITERS = MAGW / STEP;
  localparam int CNTW  = $clog2(ITERS);

  logic [MAGW-1:0] n_r;
  logic [MAGW-1:0] q_r;
  logic [DW-1:0]   rem;
  logic [DW-2:0]   d_r;
  logic            neg_r;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [NW-1:0]   n_abs;
  logic [DW-1:0]   d_abs;
  logic [MAGW-1:0] n_next;
  logic [MAGW-1:0] q_next;
  logic [DW-1:0]   rem_next;

  always_comb begin
    n_abs = num[NW-1] ? NW'(-num) : NW'(num);
    d_abs = den[DW-1] ? DW'(-den) : DW'(den);
  end

  // Restoring steps: shift one dividend bit in, subtract when it fits.
  always_comb begin
    n_next   = n_r;
    q_next   = q_r;
    rem_next = rem;
    for (int k = 0; k < STEP; k++) begin
      rem_next = {rem_next[DW-2:0], n_next[MAGW-1]};
      n_next   = n_next << 1;
      if (rem_next >= {1'b0, d_r}) begin
        rem_next = rem_next - {1'b0, d_r};
        q_next   = {q_next[MAGW-2:0], 1'b1};
      end else begin
        q_next   = {q_next[MAGW-2:0], 1'b0};
      end
    end
  end

  assign q = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_r   <= n_abs[MAGW-1:0];
        d_r   <= d_abs[DW-2:0];
        neg_r <= num[NW-1] ^ den[DW-1];
        rem   <= '0;
        q_r   <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        n_r <= n_next;
        q_r <= q_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/aopt_ctrl.sv
// Controller: sequences the micro-operations of one item over the datapath.
`default_nettype none
module aopt_ctrl
  import aopt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire aopt_stat_t stat,
  output aopt_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  uop_t       pc;
  uop_t       pc_next;
  uop_t       pc_follow;
  kind_t      kind;
  logic       last_op;

  // Successor of the current micro-operation, with the item branches.
  always_comb begin
    case (pc)
      U_DIFF: begin
        if (stat.is_set) begin
          pc_follow = U_SET;
        end else if (stat.dhead_zero) begin
          pc_follow = U_STRAIGHT;
        end else begin
          pc_follow = U_DEN;
        end
      end
      U_OY:    pc_follow = U_CLIP;
      default: pc_follow = pc + 1'b1;
    endcase
  end

  // Command decode; the final step waits for a free output register.
  always_comb begin
    kind        = uop_kind(pc);
    last_op     = (pc == U_ACC) || (pc == U_SET);
    cmd.uop     = pc;
    cmd.load    = (state == ST_IDLE) && in_valid;
    cmd.issue   = (state == ST_ISSUE) && (!last_op || stat.out_free);
    cmd.capture = (cmd.issue && (kind == K_ALU)) || ((state == ST_WAIT) && stat.done);
    in_ready    = (state == ST_IDLE);
  end

  // Next state and program counter.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ISSUE;
          pc_next    = U_KDV;
        end
      end
      ST_ISSUE: begin
        if (cmd.issue) begin
          if (kind != K_ALU) begin
            state_next = ST_WAIT;
          end else if (last_op) begin
            state_next = ST_IDLE;
          end else begin
            pc_next = pc_follow;
          end
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          state_next = ST_ISSUE;
          pc_next    = pc_follow;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= U_KDV;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

endmodule
`default_nettype wire

### rtl/aopt_dp.sv
// Datapath: item registers, pose state, rotator and the shared arithmetic units.
`default_nettype none
module aopt_dp
  import aopt_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aopt_cmd_t          cmd,
  output aopt_stat_t              stat,
  input  wire logic               in_op,
  input  wire logic signed [31:0] in_vangle,
  input  wire logic signed [31:0] in_hangle,
  input  wire logic        [15:0] in_heading,
  input  wire logic signed [31:0] in_start_x,
  input  wire logic signed [31:0] in_start_y,
  input  wire logic        [15:0] diam_v,
  input  wire logic        [15:0] diam_h,
  input  wire logic signed [31:0] off_v,
  input  wire logic signed [31:0] off_h,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic                    out_sat
);

  localparam int SH = 42 - FRAC_BITS;
  localparam logic [PW-1:0] RND = PW'(1) << (SH - 1);
  localparam logic signed [LW-1:0] LIM = LW'(64'sd4294967296);

  // Item registers.
  logic               op_r;
  logic signed [31:0] va_r;
  logic signed [31:0] ha_r;
  logic        [15:0] head_r;
  logic signed [31:0] sx_r;
  logic signed [31:0] sy_r;

  // Pose state.
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic        [31:0] last_vd;
  logic        [31:0] last_hd;
  logic        [15:0] last_head;

  // Work registers.
  logic        [33:0]     kd;
  logic        [31:0]     vd;
  logic        [31:0]     hd;
  logic signed [31:0]     dv;
  logic signed [31:0]     dh;
  logic signed [15:0]     dhead;
  logic signed [DW-1:0]   den_r;
  logic signed [SW-1:0]   s_r;
  logic signed [NW-1:0]   num_r;
  logic signed [LW-1:0]   lxw;
  logic signed [LW-1:0]   lyw;
  logic signed [LXW-1:0]  lx;
  logic signed [LXW-1:0]  ly;
  logic signed [CW-1:0]   rx;
  logic signed [CW-1:0]   ry;
  logic                   sat_r;

  // Rotator registers.
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [ZW-1:0] cz;
  logic        [4:0]    cidx;
  logic                 cbusy;
  logic                 cdone;

  // Unit connections.
  kind_t                kind;
  logic                 mul_start;
  logic                 div_start;
  logic                 cor_start;
  logic signed [MW-1:0] m_a;
  logic signed [MW-1:0] m_b;
  logic signed [PW-1:0] mul_p;
  logic                 mul_done;
  logic signed [QW-1:0] div_q;
  logic                 div_done;

  // Combinational helpers.
  logic        [31:0]   va_mag;
  logic        [31:0]   ha_mag;
  logic signed [PW-1:0] p_sh30;
  logic        [PW-1:0] w_round;
  logic        [31:0]   w_mag;
  logic                 w_neg;
  logic        [31:0]   w_dist;
  logic        [16:0]   t2;
  logic        [31:0]   c_ang;
  logic        [31:0]   c_ang_off;
  logic signed [CW-1:0] c_x0;
  logic signed [CW-1:0] c_y0;
  logic signed [CW-1:0] c_dx;
  logic signed [CW-1:0] c_dy;
  logic signed [ZW-1:0] c_at;
  logic                 clip_x_hi;
  logic                 clip_x_lo;
  logic                 clip_y_hi;
  logic                 clip_y_lo;
  logic signed [36:0]   sum_x;
  logic signed [36:0]   sum_y;
  logic signed [31:0]   new_x;
  logic signed [31:0]   new_y;
  logic                 sat_x;
  logic                 sat_y;

  assign kind      = uop_kind(cmd.uop);
  assign mul_start = cmd.issue && (kind == K_MUL);
  assign div_start = cmd.issue && (kind == K_DIV);
  assign cor_start = cmd.issue && (kind == K_COR);

  always_comb begin
    stat.done       = mul_done | div_done | cdone;
    stat.is_set     = op_r;
    stat.dhead_zero = (head_r == last_head);
    stat.out_free   = !out_valid || out_ready;
  end

  // Wheel angle magnitudes.
  always_comb begin
    va_mag = va_r[31] ? 32'(-va_r) : 32'(va_r);
    ha_mag = ha_r[31] ? 32'(-ha_r) : 32'(ha_r);
  end

  // Multiplier operand selection.
  always_comb begin
    case (cmd.uop)
      U_KDV: begin
        m_a = $signed({24'd0, diam_v});
        m_b = $signed({23'd0, DIST_K});
      end
      U_DV: begin
        m_a = $signed({8'd0, va_mag});
        m_b = $signed({6'd0, kd});
      end
      U_KDH: begin
        m_a = $signed({24'd0, diam_h});
        m_b = $signed({23'd0, DIST_K});
      end
      U_DH: begin
        m_a = $signed({8'd0, ha_mag});
        m_b = $signed({6'd0, kd});
      end
      U_DEN: begin
        m_a = MW'(dhead);
        m_b = $signed({22'd0, RAD_Q30_PER_UNIT});
      end
      U_SGAIN, U_GY: begin
        m_a = MW'(cy);
        m_b = $signed({10'd0, CORDIC_GAIN});
      end
      U_GX: begin
        m_a = MW'(cx);
        m_b = $signed({10'd0, CORDIC_GAIN});
      end
      U_PX: begin
        m_a = MW'(s_r);
        m_b = MW'(dh);
      end
      U_OX: begin
        m_a = MW'(s_r);
        m_b = MW'(off_h);
      end
      U_PY: begin
        m_a = MW'(s_r);
        m_b = MW'(dv);
      end
      U_OY: begin
        m_a = MW'(s_r);
        m_b = MW'(off_v);
      end
      default: begin
        m_a = '0;
        m_b = '0;
      end
    endcase
  end

  // Distance from a wheel product: round half away from zero, then restore sign.
  always_comb begin
    p_sh30  = mul_p >>> 30;
    w_round = mul_p + RND;
    w_mag   = w_round[SH +: 32];
    w_neg   = (cmd.uop == U_DV) ? va_r[31] : ha_r[31];
    w_dist  = w_neg ? 32'(32'd0 - w_mag) : w_mag;
  end

  // Rotator start values and the step terms.
  always_comb begin
    t2 = {last_head, 1'b0} + 17'($signed(dhead));
    if (cmd.uop == U_SIN) begin
      c_x0  = CW'(36'sh080000000);
      c_y0  = '0;
      c_ang = {dhead[15], dhead, 15'd0};
    end else begin
      c_x0  = CW'(lx);
      c_y0  = CW'(ly);
      c_ang = 32'd0 - {t2, 15'd0};
    end
    c_ang_off = c_ang + 32'h40000000;
    c_dx      = cy >>> cidx;
    c_dy      = cx >>> cidx;
    c_at      = $signed({1'b0, atan_turn(cidx)});
  end

  // Local move clipping and pose accumulation with saturation.
  always_comb begin
    clip_x_hi = lxw > LIM;
    clip_x_lo = lxw < -LIM;
    clip_y_hi = lyw > LIM;
    clip_y_lo = lyw < -LIM;
    sum_x     = 37'(acc_x) + 37'(rx);
    sum_y     = 37'(acc_y) + 37'(ry);
    sat_x     = 1'b0;
    sat_y     = 1'b0;
    if (sum_x > 37'sd2147483647) begin
      new_x = 32'sh7FFFFFFF;
      sat_x = 1'b1;
    end else if (sum_x < -37'sd2147483648) begin
      new_x = 32'sh80000000;
      sat_x = 1'b1;
    end else begin
      new_x = sum_x[31:0];
    end
    if (sum_y > 37'sd2147483647) begin
      new_y = 32'sh7FFFFFFF;
      sat_y = 1'b1;
    end else if (sum_y < -37'sd2147483648) begin
      new_y = 32'sh80000000;
      sat_y = 1'b1;
    end else begin
      new_y = sum_y[31:0];
    end
  end

  // Item capture and micro-operation results.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x     <= '0;
      acc_y     <= '0;
      last_vd   <= '0;
      last_hd   <= '0;
      last_head <= '0;
      out_valid <= 1'b0;
      sat_r     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        op_r   <= in_op;
        va_r   <= in_vangle;
        ha_r   <= in_hangle;
        head_r <= in_heading;
        sx_r   <= in_start_x;
        sy_r   <= in_start_y;
      end
      if (cmd.capture) begin
        case (cmd.uop)
          U_KDV, U_KDH: kd <= mul_p[33:0];
          U_DV:         vd <= w_dist;
          U_DH:         hd <= w_dist;
          U_DIFF: begin
            dv    <= $signed(vd - last_vd);
            dh    <= $signed(hd - last_hd);
            dhead <= $signed(head_r - last_head);
            sat_r <= 1'b0;
          end
          U_DEN:        den_r <= DW'(mul_p);
          U_SGAIN:      s_r   <= SW'(p_sh30);
          U_PX, U_PY:   num_r <= NW'(mul_p);
          U_QX:         lxw   <= LW'(div_q);
          U_QY:         lyw   <= LW'(div_q);
          U_OX:         lxw   <= lxw + LW'(p_sh30);
          U_OY:         lyw   <= lyw + LW'(p_sh30);
          U_STRAIGHT: begin
            lxw <= LW'(dh);
            lyw <= LW'(dv);
          end
          U_CLIP: begin
            lx    <= clip_x_hi ? LXW'(LIM) : (clip_x_lo ? LXW'(-LIM) : LXW'(lxw));
            ly    <= clip_y_hi ? LXW'(LIM) : (clip_y_lo ? LXW'(-LIM) : LXW'(lyw));
            sat_r <= sat_r | clip_x_hi | clip_x_lo | clip_y_hi | clip_y_lo;
          end
          U_GX:         rx <= CW'(p_sh30);
          U_GY:         ry <= CW'(p_sh30);
          U_ACC: begin
            acc_x     <= new_x;
            acc_y     <= new_y;
            last_vd   <= vd;
            last_hd   <= hd;
            last_head <= head_r;
            out_x     <= new_x;
            out_y     <= new_y;
            out_sat   <= sat_r | sat_x | sat_y;
            out_valid <= 1'b1;
          end
          U_SET: begin
            acc_x     <= sx_r;
            acc_y     <= sy_r;
            last_vd   <= vd;
            last_hd   <= hd;
            last_head <= head_r;
            out_x     <= sx_r;
            out_y     <= sy_r;
            out_sat   <= 1'b0;
            out_valid <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Iterative rotator: half-turn pre-rotation, then one micro-rotation per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
      cdone <= 1'b0;
      cidx  <= '0;
    end else begin
      cdone <= 1'b0;
      if (cor_start) begin
        if (c_ang_off[31]) begin
          cx <= -c_x0;
          cy <= -c_y0;
          cz <= ZW'($signed(c_ang ^ 32'h80000000));
        end else begin
          cx <= c_x0;
          cy <= c_y0;
          cz <= ZW'($signed(c_ang));
        end
        cidx  <= '0;
        cbusy <= 1'b1;
      end else if (cbusy) begin
        if (!cz[ZW-1]) begin
          cx <= cx - c_dx;
          cy <= cy + c_dy;
          cz <= cz - c_at;
        end else begin
          cx <= cx + c_dx;
          cy <= cy - c_dy;
          cz <= cz + c_at;
        end
        cidx <= cidx + 1'b1;
        if (cidx == 5'(CORDIC_STEPS - 1)) begin
          cbusy <= 1'b0;
          cdone <= 1'b1;
        end
      end
    end
  end

  aopt_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (m_a),
    .b     (m_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  aopt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .q     (div_q),
    .done  (div_done)
  );

endmodule
`default_nettype wire

### rtl/arc_odometry_pose_tracker.sv
// A tick with a heading change uses all twelve products, both divisions and both rotations.
// One item is processed at a time; the next is taken once the result is registered,
// and a stalled result holds the final step. Synchronous active-high reset clears the
// pose, readings and heading, sets the diameters to 2.0 inches, offsets to 0.
`default_nettype none
module arc_odometry_pose_tracker
  import aopt_pkg::*;
#(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  aopt_tick_if.sink        tick_in,
  aopt_pose_if.source      pose_out,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam logic [1:0] REG_VDIAM = 2'd0;
  localparam logic [1:0] REG_HDIAM = 2'd1;
  localparam logic [1:0] REG_VOFF  = 2'd2;
  localparam logic [1:0] REG_HOFF  = 2'd3;

  logic        [15:0] diam_v;
  logic        [15:0] diam_h;
  logic signed [31:0] off_v;
  logic signed [31:0] off_h;
  logic               cfg_wr;
  aopt_cmd_t          cmd;
  aopt_stat_t         stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      diam_v <= 16'd8192;
      diam_h <= 16'd8192;
      off_v  <= '0;
      off_h  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_VDIAM: diam_v <= pwdata[15:0];
        REG_HDIAM: diam_h <= pwdata[15:0];
        REG_VOFF:  off_v  <= $signed(pwdata);
        REG_HOFF:  off_h  <= $signed(pwdata);
        default:   ;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (paddr[3:2])
      REG_VDIAM: prdata = {16'd0, diam_v};
      REG_HDIAM: prdata = {16'd0, diam_h};
      REG_VOFF:  prdata = off_v;
      REG_HOFF:  prdata = off_h;
      default:   prdata = '0;
    endcase
  end

  aopt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (tick_in.valid),
    .in_ready (tick_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aopt_dp #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_op      (tick_in.op),
    .in_vangle  (tick_in.vertical_angle),
    .in_hangle  (tick_in.horizontal_angle),
    .in_heading (tick_in.heading_angle),
    .in_start_x (tick_in.start_x),
    .in_start_y (tick_in.start_y),
    .diam_v     (diam_v),
    .diam_h     (diam_h),
    .off_v      (off_v),
    .off_h      (off_h),
    .out_valid  (pose_out.valid),
    .out_ready  (pose_out.ready),
    .out_x      (pose_out.pos_x),
    .out_y      (pose_out.pos_y),
    .out_sat    (pose_out.saturated)
  );

endmodule
`default_nettype wire

### rtl/aopt_checker.sv
// Port-level checks of the pose tracker and their binding to the top level.
`default_nettype none
module aopt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] pos_x,
  input wire logic [31:0] pos_y,
  input wire logic        saturated
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result visible after reset");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y) &&
      $stable(saturated))
    else $error("stalled result changed");

  // An accepted transfer makes the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  // A new result only appears out of work in progress.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result produced while idle");

endmodule

bind arc_odometry_pose_tracker aopt_checker u_aopt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tick_in.valid),
  .in_ready  (tick_in.ready),
  .out_valid (pose_out.valid),
  .out_ready (pose_out.ready),
  .pos_x     (pose_out.pos_x),
  .pos_y     (pose_out.pos_y),
  .saturated (pose_out.saturated)
);
`default_nettype wire
